FILE: rtl/weighted_normal_equation_accumulator_unit_defines.svh
// Assertion helpers for the accumulator checkers
`ifndef WEIGHTED_NORMAL_EQUATION_ACCUMULATOR_UNIT_DEFINES_SVH
`define WEIGHTED_NORMAL_EQUATION_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define WNEA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wnea assertion failed");

// next-cycle implication
`define WNEA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wnea assertion failed");

`endif

FILE: rtl/wnea_pkg.sv
`default_nettype none
package wnea_pkg;
	localparam int FREE_PARAMS = 4;
	localparam int TRI_SIZE = FREE_PARAMS * (FREE_PARAMS + 1) / 2;
	localparam int LANES = FREE_PARAMS + 1;
	localparam int CHI_LANE = FREE_PARAMS;
	localparam int NUM_PHASES = FREE_PARAMS + 2;
	localparam int PH_W = $clog2(NUM_PHASES);
	localparam int LIDX_W = (FREE_PARAMS > 1) ? $clog2(FREE_PARAMS) : 1;
	localparam int TRI_W = (TRI_SIZE > 1) ? $clog2(TRI_SIZE) : 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_POINTS_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EPSILON = 2'd1;
	localparam logic [15:0] POINTS_SCALE_RST = 16'd256;
	localparam logic [15:0] WEIGHT_EPSILON_RST = 16'd1;

	localparam logic [1:0] KIND_ALPHA = 2'd0;
	localparam logic [1:0] KIND_BETA = 2'd1;
	localparam logic [1:0] KIND_CHI = 2'd2;

	// lane passes: weight product, alpha columns, beta; chi lane uses the first three
	localparam logic [PH_W-1:0] PH_T = PH_W'(0);
	localparam logic [PH_W-1:0] PH_U = PH_W'(1);
	localparam logic [PH_W-1:0] PH_CHI = PH_W'(2);
	localparam logic [PH_W-1:0] PH_BETA = PH_W'(FREE_PARAMS + 1);

	localparam logic [LIDX_W-1:0] LAST_IDX = LIDX_W'(FREE_PARAMS - 1);

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [1:0] {
		SH_0 = 2'd0,
		SH_12 = 2'd1,
		SH_16 = 2'd2
	} shift_t;

	typedef struct packed {
		logic action;
		logic excluded;
		logic signed [31:0] measured_counts;
		logic signed [31:0] model_counts;
		logic [31:0] error_bar;
		logic signed [31:0] deriv_0;
		logic signed [31:0] deriv_1;
		logic signed [31:0] deriv_2;
		logic signed [31:0] deriv_3;
	} point_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] row;
		logic [1:0] col;
		logic signed [63:0] value;
		logic last;
	} result_t;

	typedef struct packed {
		logic valid;
		logic [PH_W-1:0] phase;
	} phase_ctl_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	function automatic logic [TRI_W-1:0] tri_idx(input int r, input int c);
		return TRI_W'((r * (r + 1)) / 2 + c);
	endfunction

	function automatic logic [1:0] idx2(input logic [LIDX_W-1:0] v);
		logic [LIDX_W+1:0] w;
		w = {2'b00, v};
		return w[1:0];
	endfunction

	function automatic logic signed [31:0] deriv_of(input point_t p, input int j);
		case (j)
			0: return p.deriv_0;
			1: return p.deriv_1;
			2: return p.deriv_2;
			3: return p.deriv_3;
			default: return 32'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

FILE: rtl/wnea_if.sv
`default_nettype none
interface wnea_point_if;
	import wnea_pkg::*;
	logic valid;
	logic ready;
	point_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface wnea_result_if;
	import wnea_pkg::*;
	logic valid;
	logic ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/wnea_div.sv
`default_nettype none
module wnea_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] divisor,
	output logic done,
	output logic [31:0] quot
);
	import wnea_pkg::*;

	localparam int NUM_W = 41;
	localparam int CNT_W = $clog2(NUM_W);

	logic [63:0] rem_q;
	logic [63:0] div_q;
	logic [NUM_W-1:0] q_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [64:0] shifted;
	logic [64:0] diff;
	logic ge;

	// restoring division of 2^40, one quotient bit a cycle
	always_comb begin
		shifted = {rem_q, (cnt_q == CNT_W'(NUM_W - 1))};
		diff = shifted - {1'b0, div_q};
		ge = (shifted >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) run_q <= 1'b0;
				else cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[63:0] : shifted[63:0];
			q_q <= {q_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = (q_q[NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : q_q[31:0];
endmodule
`default_nettype wire

FILE: rtl/wnea_mul.sv
`default_nettype none
module wnea_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [63:0] op_a,
	input logic signed [63:0] op_b,
	input wnea_pkg::shift_t shift,
	output logic done,
	output logic signed [63:0] product
);
	import wnea_pkg::*;

	logic [63:0] ua_q;
	logic [63:0] ub_q;
	logic neg_q;
	shift_t shift_q;
	logic [1:0] sel_q;
	logic [1:0] sel_s1;
	logic issue_q;
	logic add_s1;
	logic fin_q;
	logic done_q;
	logic [63:0] pp_s1;
	logic [127:0] sum_q;
	logic signed [63:0] product_q;
	logic [31:0] half_a;
	logic [31:0] half_b;
	logic [127:0] pp_ext;
	logic [127:0] shr;
	logic [63:0] limit;
	logic [63:0] mag;

	// magnitude product from four 32x32 partials, then shift and saturate
	always_comb begin
		half_a = sel_q[0] ? ua_q[63:32] : ua_q[31:0];
		half_b = sel_q[1] ? ub_q[63:32] : ub_q[31:0];
		case (sel_s1)
			2'd0: pp_ext = {64'd0, pp_s1};
			2'd3: pp_ext = {pp_s1, 64'd0};
			default: pp_ext = {32'd0, pp_s1, 32'd0};
		endcase
		case (shift_q)
			SH_12: shr = sum_q >> 12;
			SH_16: shr = sum_q >> 16;
			default: shr = sum_q;
		endcase
		limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		mag = ((shr[127:64] != 64'd0) || (shr[63:0] > limit)) ? limit : shr[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			add_s1 <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			sel_q <= '0;
		end else begin
			add_s1 <= issue_q;
			fin_q <= add_s1 && (sel_s1 == 2'd3);
			done_q <= fin_q;
			if (start) begin
				issue_q <= 1'b1;
				sel_q <= '0;
			end else if (issue_q) begin
				sel_q <= sel_q + 1'b1;
				if (sel_q == 2'd3) issue_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= half_a * half_b;
		sel_s1 <= sel_q;
		if (start) begin
			ua_q <= mag64(op_a);
			ub_q <= mag64(op_b);
			neg_q <= (op_a[63] != op_b[63]);
			shift_q <= shift;
			sum_q <= '0;
		end else if (add_s1) begin
			sum_q <= sum_q + pp_ext;
		end
		if (fin_q) product_q <= neg_q ? (64'd0 - mag) : mag;
	end

	assign done = done_q;
	assign product = product_q;
endmodule
`default_nettype wire

FILE: rtl/wnea_acc.sv
`default_nettype none
module wnea_acc (
	input logic clk,
	input logic arst_n,
	input wnea_pkg::phase_ctl_t ctl,
	input logic signed [63:0] lane_res [wnea_pkg::LANES],
	input logic emit_start,
	output logic busy,
	wnea_result_if.source results
);
	import wnea_pkg::*;

	logic signed [63:0] curv_q [TRI_SIZE];
	logic signed [63:0] grad_q [FREE_PARAMS];
	logic signed [63:0] chi_q;
	logic emit_q;
	logic more_q;
	logic ovalid_q;
	logic [1:0] kind_q;
	logic [LIDX_W-1:0] r_q;
	logic [LIDX_W-1:0] c_q;
	result_t item_q;
	logic load;
	logic last_hs;
	logic [LIDX_W-1:0] hi_idx;
	logic [LIDX_W-1:0] lo_idx;
	result_t next_item;

	always_comb begin
		load = emit_q && more_q && (!ovalid_q || results.ready);
		last_hs = ovalid_q && results.ready && item_q.last;
		hi_idx = (r_q > c_q) ? r_q : c_q;
		lo_idx = (r_q > c_q) ? c_q : r_q;
		next_item.kind = kind_q;
		next_item.row = (kind_q == KIND_CHI) ? 2'd0 : idx2(r_q);
		next_item.col = (kind_q == KIND_ALPHA) ? idx2(c_q) : 2'd0;
		next_item.last = (kind_q == KIND_CHI);
		case (kind_q)
			KIND_ALPHA: next_item.value = curv_q[tri_idx(int'(hi_idx), int'(lo_idx))];
			KIND_BETA: next_item.value = grad_q[r_q];
			default: next_item.value = chi_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRI_SIZE; i++) curv_q[i] <= '0;
			for (int i = 0; i < FREE_PARAMS; i++) grad_q[i] <= '0;
			chi_q <= '0;
			emit_q <= 1'b0;
			more_q <= 1'b0;
			ovalid_q <= 1'b0;
			kind_q <= KIND_ALPHA;
			r_q <= '0;
			c_q <= '0;
		end else begin
			if (ctl.valid) begin
				for (int k = 0; k < FREE_PARAMS; k++) begin
					for (int j = k; j < FREE_PARAMS; j++) begin
						if (ctl.phase == PH_W'(k + 1))
							curv_q[tri_idx(j, k)] <= sat_add(curv_q[tri_idx(j, k)], lane_res[j]);
					end
				end
				if (ctl.phase == PH_BETA) begin
					for (int j = 0; j < FREE_PARAMS; j++)
						grad_q[j] <= sat_add(grad_q[j], lane_res[j]);
				end
				if (ctl.phase == PH_CHI) chi_q <= sat_add(chi_q, lane_res[CHI_LANE]);
			end
			if (emit_start) begin
				emit_q <= 1'b1;
				more_q <= 1'b1;
				kind_q <= KIND_ALPHA;
				r_q <= '0;
				c_q <= '0;
			end
			if (load) begin
				ovalid_q <= 1'b1;
				case (kind_q)
					KIND_ALPHA: begin
						if (c_q == LAST_IDX) begin
							c_q <= '0;
							if (r_q == LAST_IDX) begin
								r_q <= '0;
								kind_q <= KIND_BETA;
							end else begin
								r_q <= r_q + 1'b1;
							end
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
					KIND_BETA: begin
						if (r_q == LAST_IDX) begin
							r_q <= '0;
							kind_q <= KIND_CHI;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end
					default: more_q <= 1'b0;
				endcase
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
			if (last_hs) begin
				for (int i = 0; i < TRI_SIZE; i++) curv_q[i] <= '0;
				for (int i = 0; i < FREE_PARAMS; i++) grad_q[i] <= '0;
				chi_q <= '0;
				emit_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) item_q <= next_item;
	end

	assign busy = emit_q;
	assign results.valid = ovalid_q;
	assign results.data = item_q;
endmodule
`default_nettype wire

FILE: rtl/weighted_normal_equation_accumulator_unit.sv
// Weighted normal-equation accumulator. Each accumulate item (one spectrum point) is taken
// only while the block is idle: an excluded point leaves it idle, a kept point runs the
// 41-step restoring reciprocal of sigma^2+eps (skipped for a zero sigma) and six passes
// through the five multiplier lanes (four derivative lanes plus the chi-square lane), each
// pass four 32x32 partial products plus shift and saturation. A finish item streams 21
// results (alpha row-major, beta, chi-square with last set) at up to one per cycle, then
// clears the sums; the next item is taken once the last result has been taken.
`default_nettype none
module weighted_normal_equation_accumulator_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [wnea_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [wnea_pkg::CFG_DATA_W-1:0] cfg_wdata,
	wnea_point_if.sink points,
	wnea_result_if.source results
);
	import wnea_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQUARE = 6'b000010,
		ST_RECIP = 6'b000100,
		ST_DIV = 6'b001000,
		ST_LANES = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	logic [15:0] ps_q;
	logic [15:0] eps_q;
	logic [31:0] sigma_q;
	logic signed [32:0] diff_q;
	logic signed [31:0] d_q [FREE_PARAMS];
	logic [63:0] sq_q;
	logic [31:0] w_q;
	logic signed [63:0] t_q [LANES];
	logic signed [63:0] u_q;
	logic [PH_W-1:0] phase_q;
	logic lane_start_q;

	logic accept;
	logic emit_start;
	logic [64:0] s2_sum;
	logic [63:0] s2;
	logic div_done;
	logic [31:0] quot;
	logic signed [31:0] dk;
	logic signed [63:0] diff_ext;
	logic signed [63:0] lane_a [LANES];
	logic signed [63:0] lane_b [LANES];
	shift_t lane_sh [LANES];
	logic [LANES-1:0] lane_done;
	logic signed [63:0] lane_res [LANES];
	logic lanes_done;
	logic acc_busy;
	phase_ctl_t ctl;

	assign accept = points.valid && points.ready;
	assign emit_start = accept && points.data.action;
	assign points.ready = (state_q == ST_IDLE);
	assign lanes_done = &lane_done;
	assign ctl.valid = (state_q == ST_LANES) && lanes_done;
	assign ctl.phase = phase_q;

	always_comb begin
		s2_sum = {1'b0, sq_q} + {49'd0, eps_q};
		s2 = s2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s2_sum[63:0];
		dk = d_q[LIDX_W'(phase_q - 1'b1)];
		diff_ext = {{31{diff_q[32]}}, diff_q};
		for (int j = 0; j < FREE_PARAMS; j++) begin
			if (phase_q == PH_T) begin
				lane_a[j] = {32'd0, w_q};
				lane_b[j] = {{32{d_q[j][31]}}, d_q[j]};
				lane_sh[j] = SH_0;
			end else if (phase_q == PH_BETA) begin
				lane_a[j] = t_q[j];
				lane_b[j] = diff_ext;
				lane_sh[j] = SH_12;
			end else begin
				lane_a[j] = t_q[j];
				lane_b[j] = {{32{dk[31]}}, dk};
				lane_sh[j] = SH_16;
			end
		end
		// chi lane: p = pppc*diff, u = w*p, then u*p
		case (phase_q)
			PH_T: begin
				lane_a[CHI_LANE] = {48'd0, ps_q};
				lane_b[CHI_LANE] = diff_ext;
				lane_sh[CHI_LANE] = SH_0;
			end
			PH_U: begin
				lane_a[CHI_LANE] = {32'd0, w_q};
				lane_b[CHI_LANE] = t_q[CHI_LANE];
				lane_sh[CHI_LANE] = SH_16;
			end
			PH_CHI: begin
				lane_a[CHI_LANE] = u_q;
				lane_b[CHI_LANE] = t_q[CHI_LANE];
				lane_sh[CHI_LANE] = SH_16;
			end
			default: begin
				lane_a[CHI_LANE] = '0;
				lane_b[CHI_LANE] = '0;
				lane_sh[CHI_LANE] = SH_0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ps_q <= POINTS_SCALE_RST;
			eps_q <= WEIGHT_EPSILON_RST;
			phase_q <= PH_T;
			lane_start_q <= 1'b0;
		end else begin
			lane_start_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_POINTS_SCALE: ps_q <= cfg_wdata;
					REG_WEIGHT_EPSILON: eps_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (points.data.action) state_q <= ST_EMIT;
						else if (!points.data.excluded) state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (sigma_q == '0) begin
						state_q <= ST_LANES;
						phase_q <= PH_T;
						lane_start_q <= 1'b1;
					end else begin
						state_q <= ST_RECIP;
					end
				end
				ST_RECIP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_LANES;
						phase_q <= PH_T;
						lane_start_q <= 1'b1;
					end
				end
				ST_LANES: begin
					if (lanes_done) begin
						if (phase_q == PH_BETA) begin
							state_q <= ST_IDLE;
						end else begin
							phase_q <= phase_q + 1'b1;
							lane_start_q <= 1'b1;
						end
					end
				end
				ST_EMIT: if (!acc_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sigma_q <= points.data.error_bar;
			diff_q <= {points.data.measured_counts[31], points.data.measured_counts}
				- {points.data.model_counts[31], points.data.model_counts};
			for (int j = 0; j < FREE_PARAMS; j++) d_q[j] <= deriv_of(points.data, j);
		end
		if (state_q == ST_SQUARE) begin
			sq_q <= sigma_q * sigma_q;
			if (sigma_q == '0) w_q <= '0;
		end
		if ((state_q == ST_DIV) && div_done) w_q <= quot;
		if (ctl.valid && (phase_q == PH_T)) begin
			for (int j = 0; j < LANES; j++) t_q[j] <= lane_res[j];
		end
		if (ctl.valid && (phase_q == PH_U)) u_q <= lane_res[CHI_LANE];
	end

	wnea_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_RECIP),
		.divisor(s2),
		.done(div_done),
		.quot(quot)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		wnea_mul u_mul (
			.clk(clk),
			.arst_n(arst_n),
			.start(lane_start_q),
			.op_a(lane_a[g]),
			.op_b(lane_b[g]),
			.shift(lane_sh[g]),
			.done(lane_done[g]),
			.product(lane_res[g])
		);
	end

	wnea_acc u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.lane_res(lane_res),
		.emit_start(emit_start),
		.busy(acc_busy),
		.results(results)
	);
endmodule
`default_nettype wire

FILE: rtl/wnea_checker.sv
`include "weighted_normal_equation_accumulator_unit_defines.svh"
`default_nettype none
module wnea_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic [1:0] out_kind,
	input logic [63:0] out_value
);
	import wnea_pkg::*;

	`WNEA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_value))
	`WNEA_ASSERT_IMP(a_last_is_chi, clk, arst_n, out_valid && out_last, out_kind == KIND_CHI)
	`WNEA_ASSERT_NXT(a_last_ends_run, clk, arst_n, out_valid && out_ready && out_last, !out_valid)
	`WNEA_ASSERT_IMP(a_no_item_while_emit, clk, arst_n, out_valid, !in_ready)
endmodule

bind weighted_normal_equation_accumulator_unit wnea_checker u_wnea_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(points.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_last(results.data.last),
	.out_kind(results.data.kind),
	.out_value(results.data.value)
);
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import wnea_pkg::*;

	localparam int LIMIT = 600000;
	localparam int SETTLE = 250;
	localparam int RANDOM_ITEMS = 95;
	localparam int MAX_SHOWN = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic ACT_POINT = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	typedef enum logic [1:0] {ROW_ITEM, ROW_ITEM_ZERO, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		point_t p;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0] wdata;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wnea_point_if points_if();
	wnea_result_if results_if();

	weighted_normal_equation_accumulator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.points(points_if.sink),
		.results(results_if.source)
	);

	// predictor state
	logic [15:0] scale_reg;
	logic [15:0] eps_reg;
	logic signed [63:0] curv_acc[TRI_SIZE];
	logic signed [63:0] grad_acc[FREE_PARAMS];
	logic signed [63:0] chi_acc;
	result_t pending_results[$];

	int errors;
	int cycles;
	int hold_reqs;
	int hold_seen;
	int hold_cnt;
	int stall_phase;
	int stall_mode;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
		if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
		return s[63:0];
	endfunction

	// a*b/2^s, truncated toward zero, saturated
	function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
			input logic signed [63:0] b, input int s);
		logic signed [127:0] pr;
		logic [127:0] m;
		logic [127:0] lim;
		logic neg;
		pr = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		neg = a[63] ^ b[63];
		m = neg ? -pr : pr;
		m = m >> s;
		lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
		if (m > lim) m = lim;
		return neg ? -m[63:0] : m[63:0];
	endfunction

	function automatic logic [63:0] weight_of(input logic [31:0] sigma);
		logic [64:0] s2;
		logic [64:0] w;
		if (sigma == 32'd0) return 64'd0;
		s2 = {33'd0, sigma} * {33'd0, sigma} + {49'd0, eps_reg};
		if (s2[64]) s2 = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
		w = (65'd1 << 40) / s2;
		if (w > 65'hFFFF_FFFF) w = 65'hFFFF_FFFF;
		return w[63:0];
	endfunction

	task automatic accumulate_point(input point_t p);
		logic signed [63:0] diff;
		logic signed [63:0] w;
		logic signed [63:0] t;
		logic signed [63:0] pv;
		logic signed [63:0] u;
		logic signed [63:0] d[FREE_PARAMS];
		d[0] = p.deriv_0;
		d[1] = p.deriv_1;
		d[2] = p.deriv_2;
		d[3] = p.deriv_3;
		diff = 64'(p.measured_counts) - 64'(p.model_counts);
		w = weight_of(p.error_bar);
		for (int j = 0; j < FREE_PARAMS; j++) begin
			t = w * d[j];
			grad_acc[j] = add_sat64(grad_acc[j], scaled_product(t, diff, 12));
			for (int k = 0; k <= j; k++)
				curv_acc[j * (j + 1) / 2 + k] = add_sat64(curv_acc[j * (j + 1) / 2 + k],
						scaled_product(t, d[k], 16));
		end
		pv = $signed({48'd0, scale_reg}) * diff;
		u = scaled_product(w, pv, 16);
		chi_acc = add_sat64(chi_acc, scaled_product(u, pv, 16));
	endtask

	// queue the dump of all sums, then clear them; zero_known forces the typed-in all-zero values
	task automatic emit_sums(input bit zero_known);
		result_t r;
		int hi;
		int lo;
		for (int j = 0; j < FREE_PARAMS; j++)
			for (int k = 0; k < FREE_PARAMS; k++) begin
				hi = j > k ? j : k;
				lo = j > k ? k : j;
				r = '{kind: KIND_ALPHA, row: 2'(j), col: 2'(k),
						value: zero_known ? 64'sd0 : curv_acc[hi * (hi + 1) / 2 + lo], last: 1'b0};
				pending_results.push_back(r);
			end
		for (int j = 0; j < FREE_PARAMS; j++) begin
			r = '{kind: KIND_BETA, row: 2'(j), col: 2'd0,
					value: zero_known ? 64'sd0 : grad_acc[j], last: 1'b0};
			pending_results.push_back(r);
		end
		r = '{kind: KIND_CHI, row: 2'd0, col: 2'd0,
				value: zero_known ? 64'sd0 : chi_acc, last: 1'b1};
		pending_results.push_back(r);
		foreach (curv_acc[i]) curv_acc[i] = 64'sd0;
		foreach (grad_acc[i]) grad_acc[i] = 64'sd0;
		chi_acc = 64'sd0;
	endtask

	task automatic predict_item(input point_t p, input bit zero_known);
		if (p.action == ACT_FINISH) emit_sums(zero_known);
		else if (!p.excluded) accumulate_point(p);
	endtask

	// offer one item; valid stays high into the next item when no gap follows
	int burst_left;
	task automatic offer_item(input point_t p, input bit zero_known);
		int gap;
		points_if.valid <= 1'b1;
		points_if.data <= p;
		@(posedge clk);
		while (!points_if.ready) @(posedge clk);
		predict_item(p, zero_known);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				points_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_and_settle();
		points_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POINTS_SCALE) scale_reg = v;
		else if (idx == REG_WEIGHT_EPSILON) eps_reg = v;
	endtask

	function automatic logic [31:0] pick_word(input bit is_sigma);
		case ($urandom_range(0, 9))
			0: return is_sigma ? 32'd0 : 32'h8000_0000;
			1: return is_sigma ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
			2, 3: return $urandom();
			default: begin
				if (is_sigma) return $urandom_range(1, 32'h0004_0000);
				return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			end
		endcase
	endfunction

	function automatic point_t random_point();
		point_t p;
		p.action = ($urandom_range(0, 99) < 12) ? ACT_FINISH : ACT_POINT;
		p.excluded = ($urandom_range(0, 99) < 15);
		p.measured_counts = pick_word(1'b0);
		p.model_counts = pick_word(1'b0);
		p.error_bar = pick_word(1'b1);
		p.deriv_0 = pick_word(1'b0);
		p.deriv_1 = pick_word(1'b0);
		p.deriv_2 = pick_word(1'b0);
		p.deriv_3 = pick_word(1'b0);
		return p;
	endfunction

	function automatic stim_row_t item_row(input row_kind_t k, input logic act, input logic ex,
			input logic [31:0] meas, input logic [31:0] mdl, input logic [31:0] sig,
			input logic [31:0] d0, input logic [31:0] d1, input logic [31:0] d2,
			input logic [31:0] d3);
		stim_row_t r;
		r.kind = k;
		r.p = '{action: act, excluded: ex, measured_counts: meas, model_counts: mdl,
				error_bar: sig, deriv_0: d0, deriv_1: d1, deriv_2: d2, deriv_3: d3};
		r.idx = REG_POINTS_SCALE;
		r.wdata = 16'd0;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.p = '0;
		r.idx = idx;
		r.wdata = v;
		return r;
	endfunction

	stim_row_t directed[$];

	initial begin
		point_t p;
		cfg_we = 1'b0;
		cfg_idx = REG_POINTS_SCALE;
		cfg_wdata = 16'd0;
		points_if.valid = 1'b0;
		points_if.data = '0;
		hold_reqs = 0;
		scale_reg = POINTS_SCALE_RST;
		eps_reg = WEIGHT_EPSILON_RST;
		foreach (curv_acc[i]) curv_acc[i] = 64'sd0;
		foreach (grad_acc[i]) grad_acc[i] = 64'sd0;
		chi_acc = 64'sd0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sums clear after reset
		directed.push_back(item_row(ROW_ITEM_ZERO, ACT_FINISH, 1'b0, 0, 0, 0, 0, 0, 0, 0));
		// excluded and zero-sigma points leave the sums untouched
		directed.push_back(item_row(ROW_ITEM, ACT_POINT, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
				32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		directed.push_back(item_row(ROW_ITEM, ACT_POINT, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
				32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		directed.push_back(item_row(ROW_ITEM_ZERO, ACT_FINISH, 1'b1, 32'hFFFF_FFFF,
				32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				32'hFFFF_FFFF));
		directed.push_back(item_row(ROW_ITEM, ACT_POINT, 1'b0, 32'h0000_3000, 32'h0000_1000,
				32'h0000_1000, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000));
		// smallest sigma, widest data: drive the sums into saturation
		for (int i = 0; i < 3; i++)
			directed.push_back(item_row(ROW_ITEM, ACT_POINT, 1'b0, 32'h7FFF_FFFF,
					32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
					32'h8000_0000));
		directed.push_back(item_row(ROW_ITEM, ACT_FINISH, 1'b0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(cfg_row(REG_POINTS_SCALE, 16'hFFFF));
		directed.push_back(cfg_row(REG_WEIGHT_EPSILON, 16'h0000));
		directed.push_back(cfg_row(REG_UNUSED, 16'h1234));
		directed.push_back(item_row(ROW_ITEM, ACT_POINT, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
				32'd1, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF));
		directed.push_back(item_row(ROW_ITEM, ACT_POINT, 1'b0, 32'h0000_5000, 32'h0000_1000,
				32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		directed.push_back(item_row(ROW_ITEM, ACT_FINISH, 1'b0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(cfg_row(REG_POINTS_SCALE, 16'h0000));
		directed.push_back(cfg_row(REG_WEIGHT_EPSILON, 16'hFFFF));
		directed.push_back(item_row(ROW_ITEM, ACT_POINT, 1'b0, 32'h0010_0000, 32'hFFF0_0000,
				32'h0000_0800, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_4000, 32'hFFFF_C000));
		directed.push_back(item_row(ROW_ITEM, ACT_FINISH, 1'b0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(cfg_row(REG_POINTS_SCALE, POINTS_SCALE_RST));
		directed.push_back(cfg_row(REG_WEIGHT_EPSILON, WEIGHT_EPSILON_RST));

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				drain_and_settle();
				write_reg(directed[i].idx, directed[i].wdata);
			end else begin
				offer_item(directed[i].p, directed[i].kind == ROW_ITEM_ZERO);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 29) begin
				drain_and_settle();
				write_reg(REG_POINTS_SCALE, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom()));
				write_reg(REG_WEIGHT_EPSILON,
						($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom()));
			end
			p = random_point();
			// long receiver hold-off on one finish so the block backs up
			if (n == 40) begin
				p.action = ACT_FINISH;
				hold_reqs++;
			end
			offer_item(p, 1'b0);
		end
		p = random_point();
		p.action = ACT_FINISH;
		offer_item(p, 1'b0);

		points_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) $display("tb_top passed");
		else $display("tb_top failed");
		$finish;
	end

	// result side: checker and stall pattern
	initial begin
		results_if.ready = 1'b0;
		errors = 0;
		hold_seen = 0;
		hold_cnt = 0;
		stall_phase = 0;
		stall_mode = 0;
	end

	always @(posedge clk) begin
		result_t exp_r;
		result_t got;
		if (results_if.valid && results_if.ready) begin
			got = results_if.data;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected result kind=%0d row=%0d col=%0d value=%0d",
							got.kind, got.row, got.col, got.value);
			end else begin
				exp_r = pending_results.pop_front();
				if (got.kind !== exp_r.kind || got.row !== exp_r.row || got.col !== exp_r.col ||
						got.value !== exp_r.value || got.last !== exp_r.last) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("mismatch exp k=%0d r=%0d c=%0d v=%0d l=%0d got k=%0d r=%0d c=%0d v=%0d l=%0d",
								exp_r.kind, exp_r.row, exp_r.col, exp_r.value, exp_r.last,
								got.kind, got.row, got.col, got.value, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_cnt = 600;
		end
		stall_phase++;
		if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 2);
		if (hold_cnt > 0) begin
			hold_cnt--;
			results_if.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: results_if.ready <= 1'b1;
				1: results_if.ready <= ($urandom_range(0, 1) == 1);
				default: results_if.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end
endmodule
`default_nettype wire
